>>> src/bpdc_pkg.sv
package bpdc_pkg;

  // default number of keys tracked by the block
  localparam int MAX_KEYS_DEF = 8;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] VERY_LONG_PRESS_RST = 16'd5000;
  localparam logic [3:0] KEY_COUNT_RST = 4'd1;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_SAMPLE = 3'd1,
    KIND_POLL   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_STATUS = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_PRESS      = 2'd0,
    REG_VERY_LONG_PRESS = 2'd1,
    REG_KEY_COUNT       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EV_PUSH       = 3'd0,
    EV_LONG_HOLD  = 3'd1,
    EV_VLONG_HOLD = 3'd2,
    EV_SHORT_REL  = 3'd3,
    EV_LONG_REL   = 3'd4,
    EV_VLONG_REL  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_LONG_HOLD  = 3'd1,
    ST_VLONG_HOLD = 3'd2,
    ST_SHORT_REL  = 3'd3,
    ST_LONG_REL   = 3'd4,
    ST_VLONG_REL  = 3'd5
  } key_status_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] key_sel;
    logic       level_first;
    logic       level_second;
  } item_t;

  typedef struct packed {
    logic [2:0]  key_id;
    logic        has_event;
    event_t      event_code;
    key_status_t key_status;
  } result_t;

endpackage

>>> src/button_press_duration_classifier.sv
// button press duration classifier
//
// request channel: item / item_valid / item_stall. a request is taken at a
// rising edge with item_valid high and item_stall low. kinds: one ms tick,
// key level sample (two reads, ignored when they disagree), hold poll,
// clear of all statuses below key_count, and status read.
// result channel: result / result_valid / result_stall, same handshake.
// at most one result per request; ticks, clears and samples or polls with
// nothing to report give none.
// a request that is taken is evaluated from the input register, and its
// result is loaded into the result register. throughput is one request per
// cycle while nothing stalls; each request passes one input register and one result register.
// when the receiver stalls, the result register holds; the input register
// keeps draining requests that give no result and only backs up a request
// that has a result to deliver, so item_stall rises one request later.
// config port: cfg_we / cfg_index / cfg_data; the user must write it only while idle, the block does not enforce this.
// reset (rst, synchronous): ms counter to zero, no key pressed, every key
// status short release (ready), thresholds 2000 / 5000 ms, one key in use.
module button_press_duration_classifier #(
  parameter int MAX_KEYS = bpdc_pkg::MAX_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  bpdc_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bpdc_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [bpdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bpdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // index width of the per-key stores, and the width the request index is
  // widened to before it is cut down to that
  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int XW = (KW > 3) ? KW : 3;

  // configuration registers
  logic [15:0] long_press_ms;
  logic [15:0] very_long_press_ms;
  logic [3:0]  key_count;

  // block state
  logic [31:0]             now_ms;
  logic                    pressed [MAX_KEYS];
  logic [31:0]             press_start_ms [MAX_KEYS];
  bpdc_pkg::key_status_t   status [MAX_KEYS];

  // input register
  logic            s1_valid;
  bpdc_pkg::item_t s1;

  // evaluation of the request in the input register
  logic                  key_ok;
  logic [XW-1:0]         key_ext;
  logic [KW-1:0]         ki;
  logic [31:0]           spent;
  logic                  below_long;
  logic                  below_vlong;
  logic                  has_res;
  bpdc_pkg::result_t     res;
  logic                  do_tick;
  logic                  do_clear;
  logic                  set_press;
  logic                  end_press;
  logic                  st_we;
  bpdc_pkg::key_status_t st_val;
  logic                  s1_adv;
  logic                  s1_fire;

  // the input register moves on unless it would overwrite a waiting result
  assign s1_adv     = !has_res || !result_valid || !result_stall;
  assign s1_fire    = s1_valid && s1_adv;
  assign item_stall = s1_valid && !s1_adv;

  assign key_ok  = 32'(s1.key_sel) < 32'(MAX_KEYS);
  assign key_ext = XW'(s1.key_sel);
  assign ki      = key_ext[KW-1:0];

  // hold time, wrapping at 2^32
  assign spent       = now_ms - press_start_ms[ki];
  assign below_long  = spent < {16'd0, long_press_ms};
  assign below_vlong = spent < {16'd0, very_long_press_ms};

  always_comb begin
    has_res        = 1'b0;
    res.key_id     = s1.key_sel;
    res.has_event  = 1'b1;
    res.event_code = bpdc_pkg::EV_PUSH;
    res.key_status = bpdc_pkg::ST_NONE;
    do_tick        = 1'b0;
    do_clear       = 1'b0;
    set_press      = 1'b0;
    end_press      = 1'b0;
    st_we          = 1'b0;
    st_val         = bpdc_pkg::ST_NONE;
    case (s1.kind)
      bpdc_pkg::KIND_TICK: begin
        do_tick = 1'b1;
      end
      bpdc_pkg::KIND_SAMPLE: begin
        // reads that disagree are bounce, drop the sample
        if (key_ok && (s1.level_first == s1.level_second)) begin
          if (s1.level_first && !pressed[ki] && (status[ki] != bpdc_pkg::ST_NONE)) begin
            set_press = 1'b1;
            st_we     = 1'b1;
            st_val    = bpdc_pkg::ST_NONE;
            has_res   = 1'b1;
          end else if (!s1.level_first && pressed[ki]) begin
            end_press = 1'b1;
            st_we     = 1'b1;
            if (below_long) begin
              st_val = bpdc_pkg::ST_SHORT_REL;
            end else if (below_vlong) begin
              st_val = bpdc_pkg::ST_LONG_REL;
            end else begin
              st_val = bpdc_pkg::ST_VLONG_REL;
            end
            has_res        = 1'b1;
            res.event_code = bpdc_pkg::event_t'(st_val);
            res.key_status = st_val;
          end
        end
      end
      bpdc_pkg::KIND_POLL: begin
        // each hold level is reported once per press
        if (key_ok && pressed[ki]) begin
          if (!below_vlong && (status[ki] != bpdc_pkg::ST_VLONG_HOLD)) begin
            st_we          = 1'b1;
            st_val         = bpdc_pkg::ST_VLONG_HOLD;
            has_res        = 1'b1;
            res.event_code = bpdc_pkg::EV_VLONG_HOLD;
            res.key_status = bpdc_pkg::ST_VLONG_HOLD;
          end else if (below_vlong && !below_long &&
                       (status[ki] != bpdc_pkg::ST_LONG_HOLD)) begin
            st_we          = 1'b1;
            st_val         = bpdc_pkg::ST_LONG_HOLD;
            has_res        = 1'b1;
            res.event_code = bpdc_pkg::EV_LONG_HOLD;
            res.key_status = bpdc_pkg::ST_LONG_HOLD;
          end
        end
      end
      bpdc_pkg::KIND_CLEAR: begin
        do_clear = 1'b1;
      end
      bpdc_pkg::KIND_STATUS: begin
        has_res        = 1'b1;
        res.has_event  = 1'b0;
        res.key_status = key_ok ? status[ki] : bpdc_pkg::ST_NONE;
      end
      default: begin
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1 <= item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && has_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s1_fire && has_res) begin
      result <= res;
    end
  end

  // configuration writes, unused index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms      <= bpdc_pkg::LONG_PRESS_RST;
      very_long_press_ms <= bpdc_pkg::VERY_LONG_PRESS_RST;
      key_count          <= bpdc_pkg::KEY_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpdc_pkg::REG_LONG_PRESS:      long_press_ms      <= cfg_data;
        bpdc_pkg::REG_VERY_LONG_PRESS: very_long_press_ms <= cfg_data;
        bpdc_pkg::REG_KEY_COUNT:       key_count          <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // ms counter and per-key state
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= 32'd0;
      for (int i = 0; i < MAX_KEYS; i++) begin
        pressed[i] <= 1'b0;
        status[i]  <= bpdc_pkg::ST_SHORT_REL;
      end
    end else if (s1_fire) begin
      if (do_tick) begin
        now_ms <= now_ms + 32'd1;
      end
      if (set_press) begin
        pressed[ki] <= 1'b1;
      end
      if (end_press) begin
        pressed[ki] <= 1'b0;
      end
      if (st_we) begin
        status[ki] <= st_val;
      end
      // key_count above the number of keys simply covers them all
      if (do_clear) begin
        for (int i = 0; i < MAX_KEYS; i++) begin
          if (i < int'(key_count)) begin
            status[i] <= bpdc_pkg::ST_NONE;
          end
        end
      end
    end
  end

  // press start time, only read while the key is pressed
  always_ff @(posedge clk) begin
    if (s1_fire && set_press) begin
      press_start_ms[ki] <= now_ms;
    end
  end

endmodule
